// ===== rtl/core/deq_pkg.sv =====
// Package for the double-ended queue core.
// Holds the operation and status codes, cell select and controller state types.
// No dependencies.
package deq_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_LIST       = 3'd4,
    OP_CLEAR      = 3'd5
  } deq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_FROM_BUS
  } cell_sel_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_LIST
  } deq_state_t;

endpackage

// ===== rtl/core/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: controller and a chain of deq_cell.
// Depends on deq_pkg and deq_cell.
//
// Usage:
//   Input channel: in_valid / in_stall with operation and data_in. A transaction
//   completes at a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with status, data_out and last.
//   Entries sit in a row of DEPTH cells, front entry in cell 0. Push front and
//   pop front shift the whole row by one place; push back writes the cell at
//   the fill count; pop back reads the cell at fill count minus one.
//   The result of a transaction is in the output register in the cycle after
//   it is accepted. After push, pop, clear and unused codes a new transaction
//   may follow every cycle while the receiver keeps up.
//   List sends out cell 0 once per held entry, rotating the held entries by
//   one place each time, so the row is back in order at the end.
//   in_stall is high during a list and whenever the output register holds
//   a result that the receiver is stalling.
//   Reset empties the queue and the output register; cell contents are kept.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               operation,
  input  logic signed [DATA_W-1:0] data_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data_out,
  output logic                     last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  deq_state_t        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     remain, remain_next;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     back_idx;
  logic              out_load;
  logic              acc;
  logic              full;
  logic              res_valid;
  deq_status_t       res_status;
  logic [DATA_W-1:0] res_data;
  logic              res_last;
  logic [DATA_W-1:0] bus_val;
  cell_sel_t         sel [DEPTH];
  logic [DATA_W-1:0] cell_val [DEPTH];

  assign out_load = !out_valid || !out_stall;
  assign in_stall = (state == FSM_LIST) || !out_load;
  assign acc      = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign cnt_m1   = count - 1'b1;
  assign back_idx = cnt_m1[IW-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_v;
    logic [DATA_W-1:0] next_v;
    if (g == 0) begin : g_first
      assign prev_v = bus_val;
    end else begin : g_mid
      assign prev_v = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign next_v = cell_val[g];
    end else begin : g_inner
      assign next_v = cell_val[g+1];
    end
    deq_cell u_cell (
      .clk      (clk),
      .sel      (sel[g]),
      .prev_val (prev_v),
      .next_val (next_v),
      .bus_val  (bus_val),
      .val      (cell_val[g])
    );
  end

  always_comb begin
    state_next = state;
    if (state == FSM_LIST) begin
      if (out_load && remain == CW'(1)) begin
        state_next = FSM_IDLE;
      end
    end else if (acc && operation == OP_LIST && count > CW'(1)) begin
      state_next = FSM_LIST;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = CELL_HOLD;
    end
    bus_val     = data_in;
    res_valid   = 1'b0;
    res_status  = ST_OK;
    res_data    = '0;
    res_last    = 1'b1;
    count_next  = count;
    remain_next = remain;
    if (state == FSM_LIST) begin
      if (out_load) begin
        res_valid   = 1'b1;
        res_data    = cell_val[0];
        res_last    = (remain == CW'(1));
        bus_val     = cell_val[0];
        remain_next = remain - 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) < cnt_m1) begin
            sel[i] = CELL_FROM_NEXT;
          end else if (CW'(i) == cnt_m1) begin
            sel[i] = CELL_FROM_BUS;
          end
        end
      end
    end else if (acc) begin
      unique case (operation)
        OP_PUSH_BACK: begin
          res_valid = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            count_next = count + 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == count) begin
                sel[i] = CELL_FROM_BUS;
              end
            end
          end
        end
        OP_PUSH_FRONT: begin
          res_valid = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            count_next = count + 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = CELL_FROM_PREV;
            end
          end
        end
        OP_POP_BACK: begin
          res_valid = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            count_next = cnt_m1;
            res_data   = cell_val[back_idx];
          end
        end
        OP_POP_FRONT: begin
          res_valid = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            count_next = cnt_m1;
            res_data   = cell_val[0];
            for (int i = 0; i < DEPTH; i++) begin
              sel[i] = CELL_FROM_NEXT;
            end
          end
        end
        OP_LIST: begin
          res_valid = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_data    = cell_val[0];
            res_last    = (count == CW'(1));
            bus_val     = cell_val[0];
            remain_next = cnt_m1;
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) < cnt_m1) begin
                sel[i] = CELL_FROM_NEXT;
              end else if (CW'(i) == cnt_m1) begin
                sel[i] = CELL_FROM_BUS;
              end
            end
          end
        end
        OP_CLEAR: begin
          res_valid  = 1'b1;
          count_next = '0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (out_load) begin
        out_valid <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && res_valid) begin
      status   <= res_status;
      data_out <= res_data;
      last     <= res_last;
    end
  end

endmodule

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the queue chain.
// Loads from its neighbours or the shared bus as the select says.
// Depends on deq_pkg.
module deq_cell
  import deq_pkg::*;
(
  input  logic              clk,
  input  cell_sel_t         sel,
  input  logic [DATA_W-1:0] prev_val,
  input  logic [DATA_W-1:0] next_val,
  input  logic [DATA_W-1:0] bus_val,
  output logic [DATA_W-1:0] val
);

  always_ff @(posedge clk) begin
    unique case (sel)
      CELL_HOLD:      val <= val;
      CELL_FROM_PREV: val <= prev_val;
      CELL_FROM_NEXT: val <= next_val;
      CELL_FROM_BUS:  val <= bus_val;
      default:        val <= val;
    endcase
  end

endmodule

// ===== rtl/core/deq_checker.sv =====
// Port-level checks for the double-ended queue core, with its bind statement.
// Depends on deq_pkg and double_ended_queue_core.
module deq_checker
  import deq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [2:0]               operation,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] data_out,
  input logic                     last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out)
      && $stable(last))
    else $error("stalled result changed");

  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_FULL) |-> last && data_out == '0)
    else $error("empty or full status not a single zero result");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_PUSH_BACK || operation == OP_PUSH_FRONT
      || operation == OP_CLEAR) |=> out_valid && last && data_out == '0
      && status != ST_EMPTY)
    else $error("push or clear result missing or malformed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .operation (operation),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .data_out  (data_out),
  .last      (last)
);
